@@ hdl/magnetometer_calibrate_autorange_macros.svh @@
// Assertion macros used by the calibration datapath module.
// No dependencies; clk and rst_n must exist in the including scope.
`ifndef MAGNETOMETER_CALIBRATE_AUTORANGE_MACROS_SVH
`define MAGNETOMETER_CALIBRATE_AUTORANGE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define MCA_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MCA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mca_pkg.sv @@
// Types, constants and codes for the magnetometer calibration block.
// No dependencies.
package mca_pkg;

    localparam int SB    = 16;
    localparam int CNT_W = $clog2(SB + 1);

    localparam int ADDR_W = 3;
    localparam logic REG_GAIN_MODE = 1'b0;

    localparam logic [2:0] AUTO_MODE = 3'd7;
    localparam logic [2:0] TOP_STEP  = 3'd6;

    localparam int HI_LOW  = -2048;
    localparam int HI_HIGH = 2047;
    localparam int LO_LOW  = -500;
    localparam int LO_HIGH = 500;

    typedef struct packed {
        logic signed [SB-1:0] raw_x;
        logic signed [SB-1:0] raw_y;
        logic signed [SB-1:0] raw_z;
    } in_item_t;

    typedef struct packed {
        logic signed [SB-1:0] cal_x;
        logic signed [SB-1:0] cal_y;
        logic signed [SB-1:0] cal_z;
        logic [2:0]           gain_step;
        logic                 gain_changed;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRACK,
        S_CENTER,
        S_DIV_Y,
        S_WAIT_Y,
        S_DIV_Z,
        S_WAIT_Z,
        S_MUL,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic track;
        logic center;
        logic div_start_y;
        logic div_start_z;
        logic cap_qy;
        logic cap_qz;
        logic mul;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

@@ hdl/mca_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on mca_pkg.
module mca_div
    import mca_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [SB-1:0] dividend,
    input  logic [SB-1:0] divisor,
    output logic          done,
    output logic [SB-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SB-1:0]    rem_reg, rem_next;
    logic [SB-1:0]    quo_reg, quo_next;
    logic [SB-1:0]    dvs_reg, dvs_next;
    logic [SB:0]      rem_sh;
    logic [SB+1:0]    diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[SB-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SB);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (diff[SB+1])
            begin
                rem_next = rem_sh[SB-1:0];
                quo_next = {quo_reg[SB-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[SB-1:0];
                quo_next = {quo_reg[SB-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/mca_ctrl.sv @@
// Sequencing state machine for the calibration block.
// Depends on mca_pkg; drives mca_dp through command and status structs.
module mca_ctrl
    import mca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_TRACK;
            S_TRACK:  state_next = S_CENTER;
            S_CENTER: state_next = S_DIV_Y;
            S_DIV_Y:  state_next = S_WAIT_Y;
            S_WAIT_Y: if (sts.div_done) state_next = S_DIV_Z;
            S_DIV_Z:  state_next = S_WAIT_Z;
            S_WAIT_Z: if (sts.div_done) state_next = S_MUL;
            S_MUL:    state_next = S_FINISH;
            S_FINISH: if (sts.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_TRACK:  cmd.track       = 1'b1;
            S_CENTER: cmd.center      = 1'b1;
            S_DIV_Y:  cmd.div_start_y = 1'b1;
            S_WAIT_Y: cmd.cap_qy      = sts.div_done;
            S_DIV_Z:  cmd.div_start_z = 1'b1;
            S_WAIT_Z: cmd.cap_qz      = sts.div_done;
            S_MUL:    cmd.mul         = 1'b1;
            S_FINISH: cmd.finish      = sts.out_free;
            default:  cmd             = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/mca_dp.sv @@
// Datapath: range tracking, offsets, shared divider, scaling, gain ranging
// and the output register. Depends on mca_pkg, mca_div and the macro header.
`include "magnetometer_calibrate_autorange_macros.svh"

module mca_dp
    import mca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t cmd,
    output ctrl_sts_t sts,
    input  in_item_t  in_data,
    input  logic [2:0] gain_mode,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam logic signed [SB-1:0] S_TOP = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_BOT = {1'b1, {(SB-1){1'b0}}};

    function automatic logic [SB-1:0] centre_f(input logic signed [SB-1:0] s,
                                               input logic signed [SB-1:0] lo,
                                               input logic signed [SB-1:0] hi);
        logic signed [SB:0] sum;
        logic signed [SB:0] adj;
        logic signed [SB:0] mid;
        sum = (SB+1)'(hi) + (SB+1)'(lo);
        // truncate toward zero: bias negative sums by one before the shift
        adj = sum + {{SB{1'b0}}, sum[SB]};
        mid = adj >>> 1;
        return s - mid[SB-1:0];
    endfunction

    function automatic logic [SB-1:0] range_f(input logic signed [SB-1:0] lo,
                                              input logic signed [SB-1:0] hi);
        logic signed [SB:0] d;
        d = (SB+1)'(hi) - (SB+1)'(lo);
        return d[SB-1:0];
    endfunction

    in_item_t             smp_reg;
    logic signed [SB-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg, z_min_reg, z_max_reg;
    logic signed [SB-1:0] off_x_reg, off_y_reg, off_z_reg;
    logic [SB-1:0]        xr_reg, ry_reg, rz_reg;
    logic [SB-1:0]        qy_reg, qz_reg;
    logic signed [SB-1:0] cal_y_reg, cal_z_reg;
    logic [2:0]           auto_step_reg, auto_step_next;
    logic                 out_valid_reg;
    out_item_t            out_data_reg;
    out_item_t            out_next;

    logic                 div_start;
    logic [SB-1:0]        div_divisor;
    logic                 div_done;
    logic [SB-1:0]        div_quo;
    logic [2*SB-1:0]      prod_y, prod_z;
    logic                 big, quiet, changed;

    assign div_start   = cmd.div_start_y | cmd.div_start_z;
    assign div_divisor = cmd.div_start_z ? rz_reg : ry_reg;

    mca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (xr_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign prod_y = {{SB{1'b0}}, off_y_reg} * {{SB{1'b0}}, qy_reg};
    assign prod_z = {{SB{1'b0}}, off_z_reg} * {{SB{1'b0}}, qz_reg};

    always_comb
    begin
        big = (off_x_reg < HI_LOW) || (off_x_reg > HI_HIGH) ||
              (cal_y_reg < HI_LOW) || (cal_y_reg > HI_HIGH) ||
              (cal_z_reg < HI_LOW) || (cal_z_reg > HI_HIGH);
        quiet = (off_x_reg > LO_LOW) && (off_x_reg < LO_HIGH) &&
                (cal_y_reg > LO_LOW) && (cal_y_reg < LO_HIGH) &&
                (cal_z_reg > LO_LOW) && (cal_z_reg < LO_HIGH);
        auto_step_next = auto_step_reg;
        changed        = 1'b0;
        if (gain_mode == AUTO_MODE)
        begin
            if ((auto_step_reg < TOP_STEP) && big)
            begin
                auto_step_next = auto_step_reg + 3'd1;
                changed        = 1'b1;
            end
            else if ((auto_step_reg != 3'd0) && quiet)
            begin
                auto_step_next = auto_step_reg - 3'd1;
                changed        = 1'b1;
            end
        end
        out_next.cal_x        = off_x_reg;
        out_next.cal_y        = cal_y_reg;
        out_next.cal_z        = cal_z_reg;
        out_next.gain_step    = (gain_mode == AUTO_MODE) ? auto_step_next : gain_mode;
        out_next.gain_changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg     <= S_TOP;
            y_min_reg     <= S_TOP;
            z_min_reg     <= S_TOP;
            x_max_reg     <= S_BOT;
            y_max_reg     <= S_BOT;
            z_max_reg     <= S_BOT;
            auto_step_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.track)
            begin
                if (smp_reg.raw_x < x_min_reg) x_min_reg <= smp_reg.raw_x;
                if (smp_reg.raw_x > x_max_reg) x_max_reg <= smp_reg.raw_x;
                if (smp_reg.raw_y < y_min_reg) y_min_reg <= smp_reg.raw_y;
                if (smp_reg.raw_y > y_max_reg) y_max_reg <= smp_reg.raw_y;
                if (smp_reg.raw_z < z_min_reg) z_min_reg <= smp_reg.raw_z;
                if (smp_reg.raw_z > z_max_reg) z_max_reg <= smp_reg.raw_z;
            end
            if (cmd.finish)
            begin
                auto_step_reg <= auto_step_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            smp_reg <= in_data;
        if (cmd.center)
        begin
            off_x_reg <= centre_f(smp_reg.raw_x, x_min_reg, x_max_reg);
            off_y_reg <= centre_f(smp_reg.raw_y, y_min_reg, y_max_reg);
            off_z_reg <= centre_f(smp_reg.raw_z, z_min_reg, z_max_reg);
            xr_reg    <= range_f(x_min_reg, x_max_reg);
            ry_reg    <= range_f(y_min_reg, y_max_reg);
            rz_reg    <= range_f(z_min_reg, z_max_reg);
        end
        // a zero range leaves the axis unscaled
        if (cmd.cap_qy)
            qy_reg <= (ry_reg == '0) ? SB'(1) : div_quo;
        if (cmd.cap_qz)
            qz_reg <= (rz_reg == '0) ? SB'(1) : div_quo;
        if (cmd.mul)
        begin
            cal_y_reg <= prod_y[SB-1:0];
            cal_z_reg <= prod_z[SB-1:0];
        end
        if (cmd.finish)
            out_data_reg <= out_next;
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    `MCA_ASSERT(a_finish_free, !cmd.finish || sts.out_free, "result overwritten before transfer")
    `MCA_ASSERT(a_auto_top, auto_step_reg <= TOP_STEP, "auto gain step beyond top step")
    `MCA_ASSERT_NEXT(a_step_move, cmd.finish,
        (auto_step_reg == $past(auto_step_reg)) ||
        (auto_step_reg == $past(auto_step_reg) + 3'd1) ||
        (auto_step_reg == $past(auto_step_reg) - 3'd1),
        "auto gain step moved by more than one")
    `MCA_ASSERT_NEXT(a_fixed_hold, cmd.finish && (gain_mode != AUTO_MODE),
        $stable(auto_step_reg) && !out_data_reg.gain_changed,
        "auto gain step changed in fixed mode")

endmodule

@@ hdl/magnetometer_calibrate_autorange.sv @@
// Magnetometer hard-iron calibration with automatic gain ranging.
// Each sample passes through range tracking, centring, two divisions on the shared
// iterative divider, scaling and the finish step; one sample at a time, so the next
// input transfer waits until the last result is registered. A stalled result holds the next.
// Reset: min trackers to full scale, auto gain step 0, gain_mode 0, no result pending.
module magnetometer_calibrate_autorange
    import mca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data
);

    logic [2:0] gain_mode_reg;
    ctrl_cmd_t  cmd;
    ctrl_sts_t  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_mode_reg <= 3'd0;
        else if (psel && penable && pwrite && (paddr[2] == REG_GAIN_MODE))
            gain_mode_reg <= pwdata[2:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GAIN_MODE) ? {29'd0, gain_mode_reg} : 32'd0;

    mca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    mca_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .gain_mode (gain_mode_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
